@@ hw/rtl/ump_pkg.sv @@
// package for the update manifest parser
// types, constants and helper functions shared by all modules
`timescale 1ns / 1ps
package ump_pkg;
  localparam int unsigned TargetCapacity = 32;

  localparam logic [1:0] PH_SKIP  = 2'd0;
  localparam logic [1:0] PH_KEY   = 2'd1;
  localparam logic [1:0] PH_VALUE = 2'd2;

  typedef enum logic [2:0] {
    K_NONE, K_VERSION, K_TARGET, K_SIZE, K_HASH, K_GEN
  } key_kind_e;

  localparam logic [3:0] REC_STATUS  = 4'd0;
  localparam logic [3:0] REC_VERSION = 4'd1;
  localparam logic [3:0] REC_GEN     = 4'd2;
  localparam logic [3:0] REC_SIZE    = 4'd3;
  localparam logic [3:0] REC_HASH0   = 4'd4;
  localparam logic [3:0] REC_HASH3   = 4'd7;
  localparam logic [3:0] REC_TLEN    = 4'd8;
  localparam logic [3:0] REC_TGT0    = 4'd9;
  localparam logic [3:0] REC_TGT3    = 4'd12;

  localparam logic [7:0] CH_EQ = 8'h3d;
  localparam logic [7:0] CH_LF = 8'h0a;
  localparam logic [7:0] CH_CR = 8'h0d;
  localparam logic [7:0] CH_SP = 8'h20;

  // snapshot handed from parser to emitter on the last byte
  typedef struct packed {
    logic        ok;
    logic [31:0] version;
    logic [31:0] generation;
    logic [63:0] size;
    logic [255:0] hash;
    logic [6:0]  tlen;
    logic [255:0] tgt;
  } snap_t;

  function automatic logic [4:0] hex_nib(input logic [7:0] c);
    logic [4:0] r;
    r = 5'h10;
    if (c >= 8'h30 && c <= 8'h39) r = {1'b0, c[3:0]};
    else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46))
      r = {1'b0, c[3:0] + 4'd9};
    return r;
  endfunction
endpackage

@@ hw/rtl/ump_parser.sv @@
// byte-wise key/value parser: combinational byte decode, registered field storage
// depends on ump_pkg
`timescale 1ns / 1ps
module ump_parser import ump_pkg::*; #(
  parameter int unsigned TARGET_CAPACITY = TargetCapacity
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic [7:0] in_byte_i,
  input  logic       in_last_i,
  output logic       snap_valid_o,
  output snap_t      snap_o
);
  localparam int unsigned TMax = TARGET_CAPACITY - 1;
  localparam int unsigned TW = $clog2(TMax + 1);

  logic [1:0]  phase_q, phase_d;
  logic [3:0]  klen_q, klen_d;
  logic [23:0] klead_q, klead_d;
  logic [6:0]  vlen_q, vlen_d;
  logic [63:0] acc_q, acc_d;
  logic [7:0]  phash_q [32];
  logic        pbad_q, pbad_d;
  logic [255:0] hash_q;
  logic [7:0]  tgt_q [TMax];
  logic [TW-1:0] tlen_q, tlen_d;
  logic [31:0] ver_q, ver_d, gen_q, gen_d;
  logic [63:0] size_q, size_d;
  logic [4:0]  seen_q, seen_d;
  logic        abort_q, abort_d;
  logic        hash_commit, tgt_wr, ph_wr, clr;
  logic [4:0]  nib;
  logic [3:0]  nib_v;
  logic [7:0]  ph_wdata;
  key_kind_e   kind;
  key_kind_e   kind_c;
  logic        commit;

  always_comb begin
    kind = K_NONE;
    if (klen_q == 4'd7 && klead_q == 24'h726576) kind = K_VERSION;
    else if (klen_q == 4'd6 && klead_q[15:0] == 16'h6174) kind = K_TARGET;
    else if (klen_q == 4'd4 && klead_q[15:0] == 16'h6973) kind = K_SIZE;
    else if (klen_q == 4'd4 && klead_q[15:0] == 16'h6168) kind = K_HASH;
    else if (klen_q == 4'd10 && klead_q[15:0] == 16'h6567) kind = K_GEN;
  end

  assign nib = hex_nib(in_byte_i);
  assign nib_v = nib[3:0] & {4{!nib[4]}};
  assign ph_wdata = vlen_q[0] ? (phash_q[vlen_q[5:1]] | {4'd0, nib_v}) : {nib_v, 4'd0};

  always_comb begin
    phase_d = phase_q; klen_d = klen_q; klead_d = klead_q; vlen_d = vlen_q;
    acc_d = acc_q; pbad_d = pbad_q; tlen_d = tlen_q; ver_d = ver_q; gen_d = gen_q;
    size_d = size_q; seen_d = seen_q; abort_d = abort_q;
    hash_commit = 1'b0; tgt_wr = 1'b0; ph_wr = 1'b0; commit = 1'b0;
    kind_c = K_NONE;
    if (!abort_q) begin
      case (phase_q)
        PH_VALUE: begin
          if (in_byte_i == CH_LF || in_byte_i == CH_CR) commit = 1'b1;
          else begin
            if (kind == K_VERSION || kind == K_SIZE || kind == K_GEN) begin
              if (in_byte_i >= 8'h30 && in_byte_i <= 8'h39)
                acc_d = (acc_q << 3) + (acc_q << 1) + {60'd0, in_byte_i[3:0]};
            end else if (kind == K_TARGET) begin
              if (vlen_q < 7'(TMax)) begin
                tgt_wr = 1'b1;
                tlen_d = TW'(vlen_q + 7'd1);
              end
            end else if (kind == K_HASH && vlen_q < 7'd64) begin
              ph_wr = 1'b1;
              if (nib[4]) pbad_d = 1'b1;
            end
            if (vlen_q < 7'd64) vlen_d = vlen_q + 7'd1;
          end
        end
        PH_KEY: begin
          if (in_byte_i == CH_EQ) begin
            phase_d = PH_VALUE; vlen_d = '0; acc_d = '0; pbad_d = 1'b0;
            if (kind == K_TARGET) tlen_d = '0;
          end else begin
            if (klen_q == 4'd1) klead_d[15:8] = in_byte_i;
            if (klen_q == 4'd2) klead_d[23:16] = in_byte_i;
            if (klen_q < 4'd15) klen_d = klen_q + 4'd1;
          end
        end
        default: begin
          if (!(in_byte_i == CH_LF || in_byte_i == CH_CR || in_byte_i == CH_SP)) begin
            if (in_byte_i == CH_EQ) begin
              klen_d = '0; klead_d = '0;
              phase_d = PH_VALUE; vlen_d = '0; acc_d = '0; pbad_d = 1'b0;
            end else begin
              klead_d = {16'd0, in_byte_i}; klen_d = 4'd1; phase_d = PH_KEY;
            end
          end
        end
      endcase
      if (in_last_i && phase_d == PH_VALUE) commit = 1'b1;
      // an empty key opened this cycle belongs to no field
      kind_c = (klen_d == 4'd0) ? K_NONE : kind;
      if (commit) begin
        phase_d = PH_SKIP;
        case (kind_c)
          K_VERSION: begin ver_d = acc_d[31:0]; seen_d[0] = 1'b1; end
          K_TARGET:  seen_d[1] = 1'b1;
          K_SIZE:    begin size_d = acc_d; seen_d[2] = 1'b1; end
          K_HASH: begin
            if (vlen_d >= 7'd64) begin
              if (pbad_d) abort_d = 1'b1;
              else begin hash_commit = 1'b1; seen_d[3] = 1'b1; end
            end
          end
          K_GEN:     begin gen_d = acc_d[31:0]; seen_d[4] = 1'b1; end
          default: ;
        endcase
      end
    end
  end

  assign clr = in_valid_i && in_last_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_SKIP; klen_q <= '0; klead_q <= '0; vlen_q <= '0; acc_q <= '0;
      pbad_q <= 1'b0; tlen_q <= '0; ver_q <= '0; gen_q <= '0; size_q <= '0;
      seen_q <= '0; abort_q <= 1'b0; hash_q <= '0; snap_valid_o <= 1'b0;
      for (int i = 0; i < TMax; i++) tgt_q[i] <= '0;
    end else begin
      snap_valid_o <= clr;
      if (clr) begin
        phase_q <= PH_SKIP; klen_q <= '0; klead_q <= '0; vlen_q <= '0; acc_q <= '0;
        pbad_q <= 1'b0; tlen_q <= '0; ver_q <= '0; gen_q <= '0; size_q <= '0;
        seen_q <= '0; abort_q <= 1'b0; hash_q <= '0;
        for (int i = 0; i < TMax; i++) tgt_q[i] <= '0;
      end else if (in_valid_i) begin
        phase_q <= phase_d; klen_q <= klen_d; klead_q <= klead_d; vlen_q <= vlen_d;
        acc_q <= acc_d; pbad_q <= pbad_d; tlen_q <= tlen_d; ver_q <= ver_d;
        gen_q <= gen_d; size_q <= size_d; seen_q <= seen_d; abort_q <= abort_d;
        if (tgt_wr) tgt_q[vlen_q[TW-1:0]] <= in_byte_i;
        if (hash_commit)
          for (int i = 0; i < 32; i++) hash_q[8*i +: 8] <= phash_q[i];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && ph_wr) phash_q[vlen_q[5:1]] <= ph_wdata;
  end

  // final snapshot uses next-state values of the last byte
  always_ff @(posedge clk_i) begin
    if (clr) begin
      snap_o.ok <= !abort_d && (seen_d == 5'h1f);
      snap_o.version <= ver_d;
      snap_o.generation <= gen_d;
      snap_o.size <= size_d;
      for (int i = 0; i < 32; i++)
        snap_o.hash[8*i +: 8] <= !hash_commit ? hash_q[8*i +: 8]
                                 : (ph_wr && vlen_q[5:1] == 5'(i)) ? ph_wdata
                                 : phash_q[i];
      snap_o.tlen <= 7'(tlen_d);
      for (int i = 0; i < 32; i++) begin
        if (i < TMax && TW'(i) < tlen_d)
          snap_o.tgt[8*i +: 8] <= (tgt_wr && vlen_q[TW-1:0] == TW'(i)) ? in_byte_i
                                  : tgt_q[i < TMax ? i : 0];
        else snap_o.tgt[8*i +: 8] <= 8'd0;
      end
    end
  end
endmodule

@@ hw/rtl/ump_emitter.sv @@
// record sequencer: sends status and field records from the snapshot
// depends on ump_pkg
`timescale 1ns / 1ps
module ump_emitter import ump_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        snap_valid_i,
  input  snap_t       snap_i,
  output logic        busy_o,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [3:0]  kind_o,
  output logic [63:0] value_o,
  output logic        last_o
);
  snap_t      s_q;
  logic [3:0] idx_q;
  logic       act_q;

  assign busy_o = act_q;
  assign out_valid_o = act_q;
  assign kind_o = idx_q;
  assign last_o = !s_q.ok || idx_q == REC_TGT3;

  always_comb begin
    value_o = '0;
    case (idx_q)
      REC_STATUS:  value_o = {63'd0, !s_q.ok};
      REC_VERSION: value_o = {32'd0, s_q.version};
      REC_GEN:     value_o = {32'd0, s_q.generation};
      REC_SIZE:    value_o = s_q.size;
      REC_TLEN:    value_o = {57'd0, s_q.tlen};
      default: begin
        if (idx_q inside {[REC_HASH0:REC_HASH3]})
          value_o = s_q.hash[64*(idx_q - REC_HASH0) +: 64];
        else if (idx_q inside {[REC_TGT0:REC_TGT3]})
          value_o = s_q.tgt[64*(idx_q - REC_TGT0) +: 64];
        else value_o = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_q <= 1'b0; idx_q <= '0;
    end else if (snap_valid_i) begin
      act_q <= 1'b1; idx_q <= REC_STATUS;
    end else if (act_q && out_ready_i) begin
      if (last_o) act_q <= 1'b0;
      idx_q <= idx_q + 4'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (snap_valid_i) s_q <= snap_i;
  end
endmodule

@@ hw/rtl/update_manifest_parser.sv @@
// top level of the update manifest parser: parser plus record emitter
// depends on ump_pkg, ump_parser, ump_emitter
// one byte per cycle unless input is stalled; ordinary bytes give no record
// last byte's snapshot registers in parser, then emitter; then one record per ready cycle
// input stalls from the cycle after the last byte until its final record is taken
// asynchronous active-low reset clears parse state and stored fields, not the hash byte buffer or snapshots
`timescale 1ns / 1ps
module update_manifest_parser import ump_pkg::*; #(
  parameter int unsigned TARGET_CAPACITY = TargetCapacity
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,  // text_byte
  input  logic        s_axis_tlast,  // end_of_manifest
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [71:0] m_axis_tdata,  // record_kind[3:0], record_value[67:4], zero pad
  output logic        m_axis_tlast   // last_of_run
);
  logic       acc, snap_valid, busy;
  snap_t      snap;
  logic [3:0] kind;
  logic [63:0] value;

  assign s_axis_tready = !busy && !snap_valid;
  assign acc = s_axis_tvalid && s_axis_tready;

  ump_parser #(.TARGET_CAPACITY(TARGET_CAPACITY)) u_parser (
    .clk_i, .rst_ni, .in_valid_i(acc), .in_byte_i(s_axis_tdata),
    .in_last_i(s_axis_tlast), .snap_valid_o(snap_valid), .snap_o(snap)
  );

  ump_emitter u_emit (
    .clk_i, .rst_ni, .snap_valid_i(snap_valid), .snap_i(snap), .busy_o(busy),
    .out_valid_o(m_axis_tvalid), .out_ready_i(m_axis_tready), .kind_o(kind),
    .value_o(value), .last_o(m_axis_tlast)
  );

  assign m_axis_tdata = {4'd0, value, kind};
endmodule

@@ hw/rtl/ump_checker.sv @@
// port-level checks for the update manifest parser
// bound to update_manifest_parser; depends on ump_pkg
`timescale 1ns / 1ps
module ump_checker import ump_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [71:0] m_axis_tdata,
  input logic        m_axis_tlast
);
  a_no_in_while_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !(s_axis_tvalid && s_axis_tready))
    else $error("input taken during output");
  a_kind_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[3:0] <= REC_TGT3) else $error("bad kind");
  a_first_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !$past(m_axis_tvalid)) |-> m_axis_tdata[3:0] == REC_STATUS)
    else $error("run not opened by status");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output not held");
  a_last_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tlast) |->
      (m_axis_tdata[3:0] == REC_STATUS || m_axis_tdata[3:0] == REC_TGT3))
    else $error("last on wrong record");
endmodule

bind update_manifest_parser ump_checker u_ump_checker (
  .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .m_axis_tvalid,
  .m_axis_tready, .m_axis_tdata, .m_axis_tlast
);
